### rtl/oldf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oldf_pkg
// Shared types and constants of the opcode/length deframer.
// ----------------------------------------------------------------------------
package oldf_pkg;

   // Fixed field widths of the item ports
   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned ENTRY_ID_W  = 16;
   localparam int unsigned ENTRY_LEN_W = 16;

   // Header sizes in bytes
   localparam int unsigned FIXED_HEADER = 2;
   localparam int unsigned VAR_HEADER   = 4;

   typedef enum logic {
      ACTION_STREAM = 1'b0,
      ACTION_TABLE  = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_UNKNOWN = 2'd1,
      STATUS_SHORT   = 2'd2
   } status_type;

endpackage

### rtl/oldf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oldf_ram
// Generic RAM, one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module oldf_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/opcode_length_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// opcode_length_deframer
// Splits a byte stream into packets using a per-identifier length table.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/req_stall | action, data byte, table entry
//  rsp     | out       | rsp_valid/rsp_stall | byte, first, last, status
//
//  One item per cycle sustained while rsp_stall is low; a stream byte passes
//  the table read stage, then the decision and the output register, to rsp.
//  Table writes produce no rsp item.
//  After reset all 2^ID_BITS entries of the length table are cleared, one entry
//  per cycle, with req_stall held high.
//  rsp_stall holds the output register and the table read stage; req_stall
//  rises when the read stage cannot move on or while the table is cleared.
// ----------------------------------------------------------------------------
module opcode_length_deframer #(
   parameter int ID_BITS  = 16,
   parameter int LEN_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_action,
   input  logic [oldf_pkg::BYTE_W-1:0]         req_data_byte,
   input  logic [oldf_pkg::ENTRY_ID_W-1:0]     req_entry_id,
   input  logic [oldf_pkg::ENTRY_LEN_W-1:0]    req_entry_length,
   input  logic                                req_entry_variable,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [oldf_pkg::BYTE_W-1:0]         rsp_frame_byte,
   output logic                                rsp_frame_first,
   output logic                                rsp_frame_last,
   output logic [1:0]                          rsp_frame_status
);

   localparam int DEPTH   = 1 << ID_BITS;
   localparam int ENTRY_W = LEN_BITS + 1;
   localparam logic [LEN_BITS-1:0] HDR_FIXED = LEN_BITS'(oldf_pkg::FIXED_HEADER);
   localparam logic [LEN_BITS-1:0] HDR_VAR   = LEN_BITS'(oldf_pkg::VAR_HEADER);

   // table clearing pass
   logic               clr_busy_ff, clr_busy_in;
   logic [ID_BITS-1:0] clr_addr_ff, clr_addr_in;

   // read stage
   logic                        s1_valid_ff, s1_valid_in;
   logic [oldf_pkg::BYTE_W-1:0] s1_byte_ff;
   logic [oldf_pkg::BYTE_W-1:0] prev_ff;
   logic                        s1_move;

   // deframing state
   logic [LEN_BITS-1:0]         pos_ff, pos_in;
   logic [LEN_BITS-1:0]         plen_ff, plen_in;
   logic                        known_ff, known_in;
   logic                        vpend_ff, vpend_in;
   logic [oldf_pkg::BYTE_W-1:0] held_ff, held_in;

   // output register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [oldf_pkg::BYTE_W-1:0] rsp_byte_ff;
   logic                        rsp_first_ff, rsp_last_ff;
   oldf_pkg::status_type        rsp_status_ff;

   // decision results
   logic                 first_c, last_c;
   oldf_pkg::status_type status_c;

   // RAM ports
   logic               ram_wr_en, ram_rd_en;
   logic [ID_BITS-1:0] ram_wr_addr, ram_rd_addr;
   logic [ENTRY_W-1:0] ram_wr_data, ram_rd_data;

   logic accept, accept_stream, accept_table;
   logic [15:0]         id_word, vlen_word;
   logic [LEN_BITS-1:0] ent_len, var_len;
   logic                ent_var;
   logic [LEN_BITS:0]   pos_inc;

   // ------------------------------------------------------------------------
   // handshake
   // ------------------------------------------------------------------------
   assign s1_move   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = clr_busy_ff || (s1_valid_ff && !s1_move);
   assign accept    = req_valid && !req_stall;
   assign accept_stream = accept && (req_action == oldf_pkg::ACTION_STREAM);
   assign accept_table  = accept && (req_action == oldf_pkg::ACTION_TABLE);

   // ------------------------------------------------------------------------
   // table access
   // ------------------------------------------------------------------------
   // read on every stream byte, keyed by this byte and the one before it
   assign id_word     = {req_data_byte, prev_ff};
   assign ram_rd_en   = accept_stream;
   assign ram_rd_addr = id_word[ID_BITS-1:0];

   always_comb begin
      if (clr_busy_ff) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_addr_ff;
         ram_wr_data = '0;
      end else begin
         ram_wr_en   = accept_table;
         ram_wr_addr = req_entry_id[ID_BITS-1:0];
         ram_wr_data = {req_entry_variable, req_entry_length[LEN_BITS-1:0]};
      end
   end

   oldf_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(DEPTH)
   ) u_table (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + ID_BITS'(1);
         if (clr_addr_ff == {ID_BITS{1'b1}}) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // deframing decision
   // ------------------------------------------------------------------------
   assign ent_len   = ram_rd_data[LEN_BITS-1:0];
   assign ent_var   = ram_rd_data[LEN_BITS];
   assign vlen_word = {s1_byte_ff, held_ff};
   assign var_len   = vlen_word[LEN_BITS-1:0];
   assign pos_inc   = {1'b0, pos_ff} + (LEN_BITS+1)'(1);

   always_comb begin
      pos_in   = pos_ff;
      plen_in  = plen_ff;
      known_in = known_ff;
      vpend_in = vpend_ff;
      held_in  = held_ff;
      first_c  = 1'b0;
      last_c   = 1'b0;
      status_c = oldf_pkg::STATUS_OK;
      if (pos_ff == '0) begin
         first_c = 1'b1;
         held_in = s1_byte_ff;
         pos_in  = LEN_BITS'(1);
      end else if (pos_ff == LEN_BITS'(1)) begin
         if (ent_var) begin
            vpend_in = 1'b1;
            pos_in   = LEN_BITS'(2);
         end else if (ent_len == '0) begin
            status_c = oldf_pkg::STATUS_UNKNOWN;
            last_c   = 1'b1;
         end else if (ent_len < HDR_FIXED) begin
            status_c = oldf_pkg::STATUS_SHORT;
            last_c   = 1'b1;
         end else if (ent_len == HDR_FIXED) begin
            last_c = 1'b1;
         end else begin
            plen_in  = ent_len;
            known_in = 1'b1;
            pos_in   = LEN_BITS'(2);
         end
      end else if (vpend_ff) begin
         if (pos_ff == LEN_BITS'(2)) begin
            held_in = s1_byte_ff;
            pos_in  = LEN_BITS'(3);
         end else if (var_len < HDR_VAR) begin
            status_c = oldf_pkg::STATUS_SHORT;
            last_c   = 1'b1;
         end else if (var_len == HDR_VAR) begin
            last_c = 1'b1;
         end else begin
            plen_in  = var_len;
            known_in = 1'b1;
            vpend_in = 1'b0;
            pos_in   = HDR_VAR;
         end
      end else if (known_ff) begin
         if (pos_inc >= {1'b0, plen_ff}) begin
            last_c = 1'b1;
         end else begin
            pos_in = pos_inc[LEN_BITS-1:0];
         end
      end else begin
         last_c = 1'b1;
      end
      // restart the packet after its last byte
      if (last_c) begin
         pos_in   = '0;
         plen_in  = '0;
         known_in = 1'b0;
         vpend_in = 1'b0;
      end
   end

   // ------------------------------------------------------------------------
   // registers
   // ------------------------------------------------------------------------
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept_stream) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_move) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         prev_ff      <= '0;
         pos_ff       <= '0;
         plen_ff      <= '0;
         known_ff     <= 1'b0;
         vpend_ff     <= 1'b0;
         held_ff      <= '0;
      end else begin
         clr_busy_ff  <= clr_busy_in;
         clr_addr_ff  <= clr_addr_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept_stream) begin
            prev_ff <= req_data_byte;
         end
         if (s1_move) begin
            pos_ff   <= pos_in;
            plen_ff  <= plen_in;
            known_ff <= known_in;
            vpend_ff <= vpend_in;
            held_ff  <= held_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept_stream) begin
         s1_byte_ff <= req_data_byte;
      end
      if (s1_move) begin
         rsp_byte_ff   <= s1_byte_ff;
         rsp_first_ff  <= first_c;
         rsp_last_ff   <= last_c;
         rsp_status_ff <= status_c;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_frame_byte   = rsp_byte_ff;
   assign rsp_frame_first  = rsp_first_ff;
   assign rsp_frame_last   = rsp_last_ff;
   assign rsp_frame_status = rsp_status_ff;

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------
   a_clear_blocks_input: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> req_stall)
      else $error("item taken during table clearing");

   a_error_ends_frame: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_frame_status != oldf_pkg::STATUS_OK)) |-> rsp_frame_last)
      else $error("error status without last mark");

   a_first_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_first) |-> !rsp_frame_last)
      else $error("packet first byte marked last");

   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      (s1_move && last_c) |=> (pos_ff == '0) && !known_ff && !vpend_ff)
      else $error("packet state not restarted after last byte");

endmodule

### bench/oldf_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oldf_frame_checker
// Watches the request and response channels of the deframer. It keeps its
// own length table and packet state, predicts the output item of every
// accepted stream byte and compares each accepted response field by field.
// ----------------------------------------------------------------------------
module oldf_frame_checker #(
   parameter int ID_BITS  = 16,
   parameter int LEN_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_stall,
   input  logic                             req_action,
   input  logic [oldf_pkg::BYTE_W-1:0]      req_data_byte,
   input  logic [oldf_pkg::ENTRY_ID_W-1:0]  req_entry_id,
   input  logic [oldf_pkg::ENTRY_LEN_W-1:0] req_entry_length,
   input  logic                             req_entry_variable,
   input  logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  logic [oldf_pkg::BYTE_W-1:0]      rsp_frame_byte,
   input  logic                             rsp_frame_first,
   input  logic                             rsp_frame_last,
   input  logic [1:0]                       rsp_frame_status,
   output int unsigned                      failures,
   output int unsigned                      pending,
   output int unsigned                      frames_checked
);

   typedef struct packed {
      logic [7:0]           frame_byte;
      logic                 first;
      logic                 last;
      oldf_pkg::status_type status;
   } frame_item_type;

   localparam int unsigned TABLE_DEPTH = 1 << ID_BITS;
   localparam logic [15:0] ID_MASK     = 16'(TABLE_DEPTH - 1);
   localparam logic [15:0] LEN_MASK    = 16'((1 << LEN_BITS) - 1);

   // bit 16 is the variable mark, bits 15..0 the fixed length
   logic [16:0] len_table [TABLE_DEPTH];
   logic [15:0] byte_pos;
   logic [15:0] pkt_len;
   logic        len_known;
   logic        var_pending;
   logic [7:0]  held_byte;

   frame_item_type expected_frames [$];
   int unsigned fail_cnt;
   int unsigned checked_cnt;

   task automatic end_packet();
      byte_pos    = '0;
      pkt_len     = '0;
      len_known   = 1'b0;
      var_pending = 1'b0;
   endtask

   task automatic predict_frame(input logic [7:0] b, output frame_item_type item);
      logic [15:0] id;
      logic [16:0] entry;
      logic [15:0] plen;
      item.frame_byte = b;
      item.first      = 1'b0;
      item.last       = 1'b0;
      item.status     = oldf_pkg::STATUS_OK;
      if (byte_pos == 16'd0) begin
         item.first = 1'b1;
         held_byte  = b;
         byte_pos   = 16'd1;
      end else if (byte_pos == 16'd1) begin
         id    = {b, held_byte} & ID_MASK;
         entry = len_table[id];
         plen  = entry[15:0] & LEN_MASK;
         if (entry[16]) begin
            var_pending = 1'b1;
            byte_pos    = 16'd2;
         end else if (plen == 16'd0) begin
            item.status = oldf_pkg::STATUS_UNKNOWN;
            item.last   = 1'b1;
            end_packet();
         end else if (plen < oldf_pkg::FIXED_HEADER) begin
            item.status = oldf_pkg::STATUS_SHORT;
            item.last   = 1'b1;
            end_packet();
         end else if (plen == oldf_pkg::FIXED_HEADER) begin
            item.last = 1'b1;
            end_packet();
         end else begin
            pkt_len   = plen;
            len_known = 1'b1;
            byte_pos  = 16'd2;
         end
      end else if (var_pending) begin
         if (byte_pos == 16'd2) begin
            held_byte = b;
            byte_pos  = 16'd3;
         end else begin
            plen = {b, held_byte} & LEN_MASK;
            if (plen < oldf_pkg::VAR_HEADER) begin
               item.status = oldf_pkg::STATUS_SHORT;
               item.last   = 1'b1;
               end_packet();
            end else if (plen == oldf_pkg::VAR_HEADER) begin
               item.last = 1'b1;
               end_packet();
            end else begin
               pkt_len     = plen;
               len_known   = 1'b1;
               var_pending = 1'b0;
               byte_pos    = 16'd4;
            end
         end
      end else if (len_known) begin
         if ({1'b0, byte_pos} + 17'd1 >= {1'b0, pkt_len}) begin
            item.last = 1'b1;
            end_packet();
         end else begin
            byte_pos = byte_pos + 16'd1;
         end
      end else begin
         item.last = 1'b1;
         end_packet();
      end
   endtask

   always @(posedge clock) begin
      frame_item_type want;
      frame_item_type fresh;
      if (reset) begin
         foreach (len_table[i]) len_table[i] = '0;
         held_byte = '0;
         end_packet();
         expected_frames.delete();
      end else begin
         // compare before predicting so a response never meets its own item
         if (rsp_valid && !rsp_stall) begin
            if (expected_frames.size() == 0) begin
               $error("output item 0x%02h with no item expected", rsp_frame_byte);
               fail_cnt++;
            end else begin
               want = expected_frames.pop_front();
               checked_cnt++;
               if (rsp_frame_byte !== want.frame_byte) begin
                  $error("frame_byte: expected 0x%02h, got 0x%02h",
                         want.frame_byte, rsp_frame_byte);
                  fail_cnt++;
               end
               if (rsp_frame_first !== want.first) begin
                  $error("frame_first: expected %0b, got %0b", want.first, rsp_frame_first);
                  fail_cnt++;
               end
               if (rsp_frame_last !== want.last) begin
                  $error("frame_last: expected %0b, got %0b", want.last, rsp_frame_last);
                  fail_cnt++;
               end
               if (rsp_frame_status !== want.status) begin
                  $error("frame_status: expected %0d, got %0d", want.status, rsp_frame_status);
                  fail_cnt++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (req_action == oldf_pkg::ACTION_TABLE) begin
               len_table[req_entry_id & ID_MASK] =
                  {req_entry_variable, req_entry_length & LEN_MASK};
            end else begin
               predict_frame(req_data_byte, fresh);
               expected_frames.push_back(fresh);
            end
         end
      end
      failures       <= fail_cnt;
      pending        <= expected_frames.size();
      frames_checked <= checked_cnt;
   end

endmodule

### bench/tb_opcode_length_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_opcode_length_deframer
// Drives table writes and byte streams into the deframer: a directed set of
// header cases, then random packets built against a local copy of the table,
// with unknown identifiers and short lengths mixed in. Both channels idle at
// random; the checker module predicts and compares every output item.
// ----------------------------------------------------------------------------
module tb_opcode_length_deframer;

   localparam int          ID_BITS       = 16;
   localparam int          LEN_BITS      = 16;
   localparam int unsigned ITEM_TARGET   = 1150;
   localparam int unsigned POOL_SIZE     = 8;
   localparam int unsigned MAX_NOISE_LEN = 64;
   localparam int unsigned DRAIN_CYCLES  = 10;
   // covers the table clearing pass after reset several times over
   localparam int unsigned IDLE_LIMIT    = 300000;

   logic                             clock;
   logic                             reset;
   logic                             req_valid;
   logic                             req_stall;
   logic                             req_action;
   logic [oldf_pkg::BYTE_W-1:0]      req_data_byte;
   logic [oldf_pkg::ENTRY_ID_W-1:0]  req_entry_id;
   logic [oldf_pkg::ENTRY_LEN_W-1:0] req_entry_length;
   logic                             req_entry_variable;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   logic [oldf_pkg::BYTE_W-1:0]      rsp_frame_byte;
   logic                             rsp_frame_first;
   logic                             rsp_frame_last;
   logic [1:0]                       rsp_frame_status;

   int unsigned failures;
   int unsigned pending;
   int unsigned frames_checked;

   // table contents as the stimulus sees them, used to keep packets aligned
   logic [16:0] shadow_table [1 << 16];
   logic [15:0] id_pool [POOL_SIZE];
   bit          calm;
   int unsigned items_sent;
   int unsigned entries_sent;
   int unsigned packets_sent;
   int unsigned idle_cycles;
   int unsigned stall_left;

   opcode_length_deframer #(
      .ID_BITS  (ID_BITS),
      .LEN_BITS (LEN_BITS)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_action         (req_action),
      .req_data_byte      (req_data_byte),
      .req_entry_id       (req_entry_id),
      .req_entry_length   (req_entry_length),
      .req_entry_variable (req_entry_variable),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_frame_byte     (rsp_frame_byte),
      .rsp_frame_first    (rsp_frame_first),
      .rsp_frame_last     (rsp_frame_last),
      .rsp_frame_status   (rsp_frame_status)
   );

   oldf_frame_checker #(
      .ID_BITS  (ID_BITS),
      .LEN_BITS (LEN_BITS)
   ) frame_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_action         (req_action),
      .req_data_byte      (req_data_byte),
      .req_entry_id       (req_entry_id),
      .req_entry_length   (req_entry_length),
      .req_entry_variable (req_entry_variable),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_frame_byte     (rsp_frame_byte),
      .rsp_frame_first    (rsp_frame_first),
      .rsp_frame_last     (rsp_frame_last),
      .rsp_frame_status   (rsp_frame_status),
      .failures           (failures),
      .pending            (pending),
      .frames_checked     (frames_checked)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // mostly back to back, some short gaps, a few long ones
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(11, 40);
   endfunction

   task automatic send_item(input oldf_pkg::action_type act, input logic [7:0] b,
                            input logic [15:0] id, input logic [15:0] len,
                            input logic var_bit);
      int unsigned gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_action         <= act;
      req_data_byte      <= b;
      req_entry_id       <= id;
      req_entry_length   <= len;
      req_entry_variable <= var_bit;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_byte(input logic [7:0] b);
      // table fields are don't-care on stream items: toggle them anyway
      send_item(oldf_pkg::ACTION_STREAM, b, 16'($urandom), 16'($urandom), 1'($urandom));
   endtask

   task automatic send_entry(input logic [15:0] id, input logic [15:0] len,
                             input logic var_bit);
      send_item(oldf_pkg::ACTION_TABLE, 8'($urandom), id, len, var_bit);
      shadow_table[id] = {var_bit, len};
      entries_sent++;
   endtask

   task automatic write_pool_entry();
      logic [15:0] id;
      int unsigned r;
      id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
      r  = $urandom_range(0, 99);
      if (r < 10)      send_entry(id, 16'd0, 1'b0);
      else if (r < 18) send_entry(id, 16'd1, 1'b0);
      else if (r < 26) send_entry(id, 16'd2, 1'b0);
      else if (r < 50) send_entry(id, 16'($urandom), 1'b1);
      else             send_entry(id, 16'($urandom_range(3, 24)), 1'b0);
   endtask

   // one complete frame, ending exactly where the block ends it
   task automatic send_packet(input logic [15:0] pid);
      logic [16:0] entry;
      logic [15:0] vlen;
      int unsigned total;
      int unsigned sent;
      int unsigned r;
      send_byte(pid[7:0]);
      send_byte(pid[15:8]);
      entry = shadow_table[pid];
      sent  = 2;
      if (entry[16]) begin
         r = $urandom_range(0, 99);
         if (r < 12)      vlen = 16'($urandom_range(0, 3));
         else if (r < 22) vlen = 16'(oldf_pkg::VAR_HEADER);
         else if (r < 25) vlen = 16'h00FF;
         else             vlen = 16'($urandom_range(5, 24));
         send_byte(vlen[7:0]);
         send_byte(vlen[15:8]);
         sent  = 4;
         total = (vlen < oldf_pkg::VAR_HEADER) ? oldf_pkg::VAR_HEADER : vlen;
      end else begin
         total = (entry[15:0] < oldf_pkg::FIXED_HEADER) ? oldf_pkg::FIXED_HEADER
                                                         : entry[15:0];
      end
      while (sent < total) begin
         // lookup is done by now: a write here only affects later packets
         if ($urandom_range(0, 24) == 0) write_pool_entry();
         send_byte(8'($urandom));
         sent++;
      end
      packets_sent++;
   endtask

   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         stall_left = pick_gap();
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
            $display("tb_opcode_length_deframer: FAIL");
            $finish;
         end
      end
   end

   initial begin
      int unsigned r;
      int unsigned next_phase;
      logic [15:0] noise_id;
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_action         = oldf_pkg::ACTION_STREAM;
      req_data_byte      = '0;
      req_entry_id       = '0;
      req_entry_length   = '0;
      req_entry_variable = 1'b0;
      calm               = 1'b0;
      foreach (shadow_table[i]) shadow_table[i] = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // header cases: short, exact and longer fixed lengths, variable entry
      send_entry(16'h0201, 16'd1, 1'b0);
      send_entry(16'h0302, 16'd2, 1'b0);
      send_entry(16'h0403, 16'd3, 1'b0);
      send_entry(16'h0504, 16'hFFFF, 1'b1);
      send_entry(16'hFFFF, 16'hFFFF, 1'b0);
      send_byte(8'h00);     // identifier never written: unknown
      send_byte(8'h00);
      send_byte(8'h01);     // fixed length below the header
      send_byte(8'h02);
      send_byte(8'h02);     // fixed length equal to the header
      send_byte(8'h03);
      send_byte(8'h03);
      send_byte(8'h04);
      send_byte(8'hFF);
      send_byte(8'h04);     // variable length below its header
      send_byte(8'h05);
      send_byte(8'h03);
      send_byte(8'h00);
      send_byte(8'h04);     // variable length equal to its header
      send_byte(8'h05);
      send_byte(8'h04);
      send_byte(8'h00);

      foreach (id_pool[i]) id_pool[i] = 16'($urandom);
      foreach (id_pool[i]) send_entry(id_pool[i], 16'($urandom_range(3, 24)), 1'b0);

      next_phase = items_sent + 150;
      while (items_sent < ITEM_TARGET) begin
         if (items_sent >= next_phase) begin
            calm       = ($urandom_range(0, 3) == 0);
            next_phase = items_sent + $urandom_range(80, 200);
         end
         r = $urandom_range(0, 99);
         if (r < 10) begin
            write_pool_entry();
         end else if (r < 13) begin
            send_entry(16'($urandom), 16'($urandom), 1'($urandom));
         end else if (r < 25) begin
            // random identifier, mostly unknown; skip the very long ones
            noise_id = 16'($urandom);
            while (!shadow_table[noise_id][16] &&
                   shadow_table[noise_id][15:0] > MAX_NOISE_LEN)
               noise_id = 16'($urandom);
            send_packet(noise_id);
         end else begin
            send_packet(id_pool[$urandom_range(0, POOL_SIZE - 1)]);
         end
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d input items: %0d table writes, %0d random frames",
               items_sent, entries_sent, packets_sent);
      $display("checked %0d output items, %0d mismatches", frames_checked, failures);
      if (failures == 0) begin
         $display("tb_opcode_length_deframer: PASS");
      end else begin
         $display("tb_opcode_length_deframer: FAIL");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/oldf_pkg.sv
rtl/oldf_ram.sv
rtl/opcode_length_deframer.sv
bench/oldf_frame_checker.sv
bench/tb_opcode_length_deframer.sv
